@@ rtl/indexed_list_store_top_defines.svh @@
// ----------------------------------------------------------------------------
// indexed list store assertion macros
// shared concurrent checks, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// invariant that holds at every edge out of reset
`define ILS_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ILS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// codes, field widths and sequencer states of the indexed list store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ils_pkg;

    // request field widths
    localparam int ACT_W       = 3;
    localparam int POS_W       = 16;
    localparam int ITEM_W      = 32;
    localparam int IN_TDATA_W  = 56;

    // response field widths
    localparam int IDX_OUT_W   = 10;
    localparam int LEN_OUT_W   = 11;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 56;

    // one bit over the position, wide enough for any count up to 65536
    localparam int EXT_W       = 17;
    localparam int WIDE_W      = 64;
    localparam int BIT_CNT_W   = 4;

    // actions
    localparam logic [ACT_W-1:0] ACT_GET     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_MOD    = 7'b0000100,
        S_EXEC   = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_PUT    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

endpackage

@@ rtl/indexed_list_store_top.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store_top
// bounded ordered list with get, replace, delete, append and insert at a
// signed relative position; one response per request
// a non-negative position at or past the length wraps by a bit-serial modulo
// throughput: one request at a time; shifts run at one memory move per cycle
// reset: list empties at once, no clearing pass; store contents are undefined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "indexed_list_store_top_defines.svh"

module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // action[2:0], rel_pos[18:3], item_in[50:19], zero pad[55:51]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // response channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // item_out[31:0], resolved_index[41:32], list_length[52:42], status[54:53], pad[55]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // item store: one write and one registered read port
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    state_t state_reg, state_next;

    // latched request
    logic [ACT_W-1:0]      act_reg,  act_next;
    logic [POS_W-1:0]      pos_reg,  pos_next;
    logic [DATA_WIDTH-1:0] item_reg, item_next;

    // list length
    logic [CNT_W-1:0]      count_reg, count_next;

    // resolved index and modulo remainder
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]  bit_reg, bit_next;

    // shift walker: read pointer, its stop address, read in flight
    logic [IDX_W-1:0]      rp_reg, rp_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    logic                  more_reg, more_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // response fields
    logic [DATA_WIDTH-1:0] res_item_reg, res_item_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // memory port controls
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;

    // position decode
    logic [EXT_W-1:0]      count_ext;
    logic [EXT_W-1:0]      pos_ext;
    logic [EXT_W-1:0]      back;
    logic [EXT_W-1:0]      from_end;
    logic                  pos_neg;
    logic                  list_full;
    logic [ACT_W-1:0]      eff_act;
    logic [CNT_W-1:0]      cnt_dec;
    logic [IDX_W-1:0]      cnt_m1;

    // compare-subtract unit of the bit-serial modulo
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        trial_sub;
    logic [CNT_W-1:0]      rem_step;

    // widening helpers for the response fields
    logic [WIDE_W-1:0]     item_in_wide;
    logic [WIDE_W-1:0]     res_wide;
    logic [EXT_W-1:0]      idx_wide;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign count_ext = EXT_W'(count_reg);
    assign pos_ext   = {1'b0, pos_reg};
    assign pos_neg   = pos_reg[POS_W-1];
    // magnitude of a negative position
    assign back      = {1'b1, {POS_W{1'b0}}} - pos_ext;
    assign from_end  = count_ext - back;
    assign list_full = (count_ext >= EXT_W'(DEPTH));
    // insert on an empty list behaves as append
    assign eff_act   = ((act_reg == ACT_INSERT) && (count_reg == '0)) ? ACT_APPEND : act_reg;
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign cnt_m1    = cnt_dec[IDX_W-1:0];

    assign trial     = {rem_reg, pos_reg[bit_reg]};
    assign trial_sub = trial - {1'b0, count_reg};
    assign rem_step  = (trial >= {1'b0, count_reg}) ? trial_sub[CNT_W-1:0]
                                                    : trial[CNT_W-1:0];

    assign item_in_wide = WIDE_W'(s_axis_tdata[50:19]);
    assign res_wide     = WIDE_W'(res_item_reg);
    assign idx_wide     = EXT_W'(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        rp_next        = rp_reg;
        last_next      = last_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        rd_addr_next   = rd_addr_reg;
        res_item_next  = res_item_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = item_reg;
        mem_re         = 1'b0;
        mem_raddr      = rp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tdata[2:0];
                    pos_next   = s_axis_tdata[18:3];
                    item_next  = item_in_wide[DATA_WIDTH-1:0];
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_item_next = '0;
                idx_next      = '0;
                status_next   = STAT_OK;
                state_next    = S_DONE;
                if (eff_act == ACT_APPEND)
                begin
                    if (list_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        idx_next   = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if ((eff_act == ACT_GET) || (eff_act == ACT_REPLACE) ||
                         (eff_act == ACT_DELETE) || (eff_act == ACT_INSERT))
                begin
                    priority if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else if ((eff_act == ACT_INSERT) && list_full)
                        status_next = STAT_FULL;
                    else if (pos_neg && (back > count_ext))
                        status_next = STAT_RANGE;
                    else if (pos_neg)
                    begin
                        idx_next   = from_end[IDX_W-1:0];
                        state_next = S_EXEC;
                    end
                    else if (pos_ext < count_ext)
                    begin
                        idx_next   = pos_ext[IDX_W-1:0];
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        // position wraps: remainder one bit per cycle
                        rem_next   = '0;
                        bit_next   = BIT_CNT_W'(POS_W - 1);
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                rem_next = rem_step;
                bit_next = bit_reg - BIT_CNT_W'(1);
                if (bit_reg == '0)
                begin
                    idx_next   = rem_step[IDX_W-1:0];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rp_next    = idx_reg;
                last_next  = idx_reg;
                more_next  = 1'b1;
                pend_next  = 1'b0;
                state_next = S_SHIFT;
                unique case (act_reg)
                    ACT_REPLACE:
                    begin
                        mem_we     = 1'b1;
                        more_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    ACT_GET:
                    begin
                        last_next = idx_reg;
                    end
                    ACT_DELETE:
                    begin
                        // walk up from the removed entry to the tail
                        last_next = cnt_m1;
                    end
                    ACT_INSERT:
                    begin
                        // walk down from the tail to the insert point
                        rp_next   = cnt_m1;
                        last_next = idx_reg;
                    end
                    default:
                    begin
                        more_next  = 1'b0;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // one read per cycle; write back the last one read or keep it as result
                if (more_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = rp_reg;
                    pend_next    = 1'b1;
                    rd_addr_next = rp_reg;
                    if (rp_reg == last_reg)
                        more_next = 1'b0;
                    else if (act_reg == ACT_INSERT)
                        rp_next = rp_reg - IDX_W'(1);
                    else
                        rp_next = rp_reg + IDX_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    mem_wdata = rd_data_reg;
                    if (act_reg == ACT_INSERT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_addr_reg + IDX_W'(1);
                    end
                    else if (rd_addr_reg == idx_reg)
                    begin
                        res_item_next = rd_data_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_addr_reg - IDX_W'(1);
                    end

                    if (!more_reg)
                    begin
                        if (act_reg == ACT_INSERT)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            if (act_reg == ACT_DELETE)
                                count_next = cnt_dec;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, status_reg, count_ext[LEN_OUT_W-1:0],
                                      idx_wide[IDX_OUT_W-1:0], res_wide[ITEM_W-1:0]};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pos_reg      <= pos_next;
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        rp_reg       <= rp_next;
        last_reg     <= last_next;
        rd_addr_reg  <= rd_addr_next;
        res_item_reg <= res_item_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // item store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // length never exceeds the store
    `ILS_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "list length above depth")

    // length only moves on append, delete tail or insert put
    `ILS_ASSERT_IMP(a_count_source, count_reg != $past(count_reg),
        ($past(state_reg) == S_DECODE) || ($past(state_reg) == S_SHIFT) ||
        ($past(state_reg) == S_PUT), "length changed outside an update step")

    // writes stay inside the list or one past its end
    `ILS_ASSERT_IMP(a_write_bound, mem_we, EXT_W'(mem_waddr) <= count_ext,
        "store write beyond list end")

    // a response only appears out of the done step
    `ILS_ASSERT_IMP(a_resp_source, $rose(out_valid_reg), $past(state_reg) == S_DONE,
        "response raised outside done step")

endmodule

@@ verif/tb_indexed_list_store_top.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// self-checking bench for the indexed list store: a short table of directed
// requests, a long random mix kept at small list lengths, then a few corner
// requests at the length reached; every response is compared against a
// shadow list kept in the bench or a fixed reply, under bursty input and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_list_store_top
    import ils_pkg::*;
();

    localparam int DEPTH        = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int CLK_HALF     = 4;
    localparam int RANDOM_REQS  = 520;
    localparam int MAX_REPORTS  = 40;

    // worst single request: full shift, wrap modulo, decode, longest gaps
    localparam int     WORST_REQ_CYCLES = DEPTH + 24 + 16 + 64;
    localparam longint CYCLE_LIMIT      = 64'd2400 * WORST_REQ_CYCLES * 3;
    localparam int     DRAIN_CYCLES     = DEPTH + 48;

    // response field offsets inside m_axis_tdata
    localparam int OFS_IDX    = ITEM_W;
    localparam int OFS_LEN    = OFS_IDX + IDX_OUT_W;
    localparam int OFS_STATUS = OFS_LEN + LEN_OUT_W;

    typedef struct packed {
        logic [ITEM_W-1:0]    item_out;
        logic [IDX_OUT_W-1:0] index;
        logic [LEN_OUT_W-1:0] length;
        logic [STATUS_W-1:0]  status;
    } list_reply_t;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  rel_pos;
        logic [ITEM_W-1:0] item;
        bit                fixed;
        list_reply_t       reply;
    } list_step_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow copy of the list
    logic [ITEM_W-1:0] shadow_items [DEPTH];
    int unsigned       shadow_count = 0;
    int unsigned       deepest_list = 0;

    // responses still owed by the block, oldest first
    list_reply_t pending_replies [$];
    list_step_t  step_table [$];

    int          err_cnt      = 0;
    int          req_total    = 0;
    int          random_total = 0;
    int          resp_total   = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int          burst_left   = 0;
    longint unsigned cycle_cnt = 0;

    list_reply_t seen_reply;
    list_reply_t want_reply;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          mode_left  = 0;

    indexed_list_store_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow list: apply one request, return the response it must give
    // ------------------------------------------------------------------
    function automatic list_reply_t list_model_apply(input logic [ACT_W-1:0]  action,
                                                     input logic [POS_W-1:0]  rel_pos,
                                                     input logic [ITEM_W-1:0] item);
        list_reply_t      r;
        logic [ACT_W-1:0] act;
        int unsigned      back;
        int unsigned      idx;
        int unsigned      k;
        bit               in_range;
        r        = '0;
        idx      = 0;
        in_range = 1'b1;
        // insert into an empty list behaves as append
        act = (action == ACT_INSERT && shadow_count == 0) ? ACT_APPEND : action;
        if (shadow_count != 0)
        begin
            if (rel_pos[POS_W-1])
            begin
                // negative: count back from the end, no wrap allowed
                back = 32'h10000 - rel_pos;
                if (back > shadow_count)
                    in_range = 1'b0;
                else
                    idx = shadow_count - back;
            end
            else
            begin
                // non-negative: wraps modulo the length
                idx = rel_pos % shadow_count;
            end
        end
        if (act == ACT_APPEND)
        begin
            if (shadow_count >= DEPTH)
                r.status = STAT_FULL;
            else
            begin
                r.index = IDX_OUT_W'(shadow_count);
                shadow_items[shadow_count] = item;
                shadow_count++;
            end
        end
        else if (act == ACT_GET || act == ACT_REPLACE || act == ACT_DELETE ||
                 act == ACT_INSERT)
        begin
            if (shadow_count == 0)
                r.status = STAT_EMPTY;
            else if (act == ACT_INSERT && shadow_count >= DEPTH)
                r.status = STAT_FULL;
            else if (!in_range)
                r.status = STAT_RANGE;
            else
            begin
                r.index = IDX_OUT_W'(idx);
                case (act)
                    ACT_GET:
                        r.item_out = shadow_items[idx];
                    ACT_REPLACE:
                        shadow_items[idx] = item;
                    ACT_DELETE:
                    begin
                        r.item_out = shadow_items[idx];
                        for (k = idx; k + 1 < shadow_count; k++)
                            shadow_items[k] = shadow_items[k + 1];
                        shadow_count--;
                    end
                    default:
                    begin
                        for (k = shadow_count; k > idx; k--)
                            shadow_items[k] = shadow_items[k - 1];
                        shadow_items[idx] = item;
                        shadow_count++;
                    end
                endcase
            end
        end
        // unknown actions fall through: ok status, current length
        r.length = LEN_OUT_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
                     $time, resp_total, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // request side: drive one request, predict at acceptance; requests go out
    // in bursts of random length separated by random idle gaps
    // ------------------------------------------------------------------
    task automatic send_request(input logic [ACT_W-1:0]  action,
                                input logic [POS_W-1:0]  rel_pos,
                                input logic [ITEM_W-1:0] item,
                                input bit                fixed,
                                input list_reply_t       fixed_reply);
        list_reply_t predicted;
        int          gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ACT_W - POS_W - ITEM_W){1'b0}}, item, rel_pos, action};
        do @(posedge clk); while (!s_axis_tready);
        predicted = list_model_apply(action, rel_pos, item);
        pending_replies.push_back(fixed ? fixed_reply : predicted);
        req_total++;
        if (shadow_count > deepest_list)
            deepest_list = shadow_count;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            case ($urandom_range(0, 9))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(7, 40);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 7);
        end
    endtask

    // sender pause until the block has answered everything
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic add_step(input logic [ACT_W-1:0]    action,
                            input logic [POS_W-1:0]    rel_pos,
                            input logic [ITEM_W-1:0]   item,
                            input bit                  fixed,
                            input logic [ITEM_W-1:0]   e_item,
                            input logic [IDX_OUT_W-1:0] e_index,
                            input logic [LEN_OUT_W-1:0] e_length,
                            input logic [STATUS_W-1:0] e_status);
        list_step_t s;
        s.action         = action;
        s.rel_pos        = rel_pos;
        s.item           = item;
        s.fixed          = fixed;
        s.reply.item_out = e_item;
        s.reply.index    = e_index;
        s.reply.length   = e_length;
        s.reply.status   = e_status;
        step_table.push_back(s);
    endtask

    task automatic run_step_table();
        foreach (step_table[i])
            send_request(step_table[i].action, step_table[i].rel_pos, step_table[i].item,
                         step_table[i].fixed, step_table[i].reply);
        step_table.delete();
    endtask

    // ------------------------------------------------------------------
    // random mix: lists stay short so shifts stay cheap, positions mostly
    // near the current length, some fully random 16-bit values
    // ------------------------------------------------------------------
    task automatic run_random_mix(input int count);
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        int               roll;
        list_reply_t      none;
        none = '0;
        while (random_total < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 22)
                act = ACT_GET;
            else if (roll < 36)
                act = ACT_REPLACE;
            else if (roll < 56)
                act = ACT_DELETE;
            else if (roll < 72)
                act = ACT_APPEND;
            else if (roll < 95)
                act = ACT_INSERT;
            else
                act = ACT_W'($urandom_range(ACT_INSERT + 1, (1 << ACT_W) - 1));
            // steer the length: shrink long lists, grow very short ones
            if (shadow_count > 40 && (act == ACT_APPEND || act == ACT_INSERT) &&
                $urandom_range(0, 1) == 1)
                act = ACT_DELETE;
            if (shadow_count < 3 && act == ACT_DELETE && $urandom_range(0, 1) == 1)
                act = ACT_APPEND;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: pos = POS_W'($urandom_range(0, shadow_count + 2));
                5, 6, 7:       pos = 16'h0 - 16'($urandom_range(1, shadow_count + 2));
                default:       pos = POS_W'($urandom());
            endcase
            send_request(act, pos, $urandom(), 1'b0, none);
            // unknown actions do nothing, so they do not count
            if (act <= ACT_INSERT)
                random_total++;
            if ($urandom_range(0, 59) == 0)
                hold_until_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // response side: stall on a pattern that changes mode over time
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode    <= 0;
            mode_left     <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(32, 400);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;                       // never stalls
                1:       m_axis_tready <= ($urandom_range(0, 1) == 0); // half the time
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0); // long stalls
                default: m_axis_tready <= ~m_axis_tready;             // alternating
            endcase
        end
    end

    // compare every accepted response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_reply.item_out = m_axis_tdata[ITEM_W-1:0];
            seen_reply.index    = m_axis_tdata[OFS_IDX +: IDX_OUT_W];
            seen_reply.length   = m_axis_tdata[OFS_LEN +: LEN_OUT_W];
            seen_reply.status   = m_axis_tdata[OFS_STATUS +: STATUS_W];
            resp_total++;
            if (pending_replies.size() == 0)
                report_mismatch("response with no request waiting", 64'(seen_reply), 64'd0);
            else
            begin
                want_reply = pending_replies.pop_front();
                if (seen_reply.item_out !== want_reply.item_out)
                    report_mismatch("item_out", 64'(seen_reply.item_out),
                                    64'(want_reply.item_out));
                if (seen_reply.index !== want_reply.index)
                    report_mismatch("resolved_index", 64'(seen_reply.index),
                                    64'(want_reply.index));
                if (seen_reply.length !== want_reply.length)
                    report_mismatch("list_length", 64'(seen_reply.length),
                                    64'(want_reply.length));
                if (seen_reply.status !== want_reply.status)
                    report_mismatch("status", 64'(seen_reply.status),
                                    64'(want_reply.status));
                else
                    status_seen[want_reply.status]++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("run timed out after %0d cycles, %0d responses owed",
                     cycle_cnt, pending_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        list_reply_t none;
        none = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, insert on empty, extremes of the position
        add_step(ACT_GET,     16'h0000, 32'h0,        1, 32'h0, 0, 0, STAT_EMPTY);
        add_step(ACT_REPLACE, 16'h0005, 32'h1,        1, 32'h0, 0, 0, STAT_EMPTY);
        add_step(ACT_DELETE,  16'hFFFF, 32'h0,        1, 32'h0, 0, 0, STAT_EMPTY);
        add_step(ACT_INSERT,  16'h0007, 32'hFFFFFFFF, 1, 32'h0, 0, 1, STAT_OK);
        add_step(ACT_APPEND,  16'h8000, 32'h00000000, 1, 32'h0, 1, 2, STAT_OK);
        add_step(ACT_APPEND,  16'h7FFF, 32'hA5A5A5A5, 1, 32'h0, 2, 3, STAT_OK);
        add_step(ACT_GET,     16'h0000, 32'h0,        1, 32'hFFFFFFFF, 0, 3, STAT_OK);
        add_step(ACT_GET,     16'hFFFF, 32'h0,        1, 32'hA5A5A5A5, 2, 3, STAT_OK); // -1
        add_step(ACT_GET,     16'hFFFD, 32'h0,        1, 32'hFFFFFFFF, 0, 3, STAT_OK); // -3
        add_step(ACT_GET,     16'hFFFC, 32'h0,        1, 32'h0, 0, 3, STAT_RANGE);    // -4
        add_step(ACT_GET,     16'h8000, 32'h0,        1, 32'h0, 0, 3, STAT_RANGE);    // most negative
        add_step(ACT_GET,     16'h7FFF, 32'h0,        1, 32'h0, 1, 3, STAT_OK);       // wraps to 1
        add_step(ACT_REPLACE, 16'h0001, 32'h12345678, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_INSERT,  16'h0000, 32'h80000001, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_INSERT,  16'hFFFF, 32'h7FFFFFFE, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_DELETE,  16'h0002, 32'h0,        0, 0, 0, 0, STAT_OK);
        add_step(ACT_DELETE,  16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_W'(ACT_INSERT + 1),   16'h0000, 32'h0,        0, 0, 0, 0, STAT_OK);
        add_step(ACT_W'((1 << ACT_W) - 1), 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_INSERT,  16'h0003, 32'h5555AAAA, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_REPLACE, 16'h8000, 32'h0,        0, 0, 0, 0, STAT_OK);
        add_step(ACT_DELETE,  16'h0000, 32'h0,        0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'h0001, 32'h0,        0, 0, 0, 0, STAT_OK);
        run_step_table();
        hold_until_drained();

        run_random_mix(RANDOM_REQS);
        hold_until_drained();

        // corners at the length the random mix left behind
        add_step(ACT_GET,     16'h7FFF, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'h8000, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_REPLACE, 16'hFFFF, $urandom(), 0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'h03FF, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_DELETE,  16'h0000, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'h0000, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_INSERT,  16'h0000, $urandom(), 0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'h0001, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_DELETE,  16'h03FF, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_INSERT,  16'hFFFF, $urandom(), 0, 0, 0, 0, STAT_OK);
        add_step(ACT_APPEND,  16'h0000, 32'h4, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_DELETE,  16'h0200, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'h8001, 32'h0, 0, 0, 0, 0, STAT_OK);
        add_step(ACT_GET,     16'hFFFF, 32'h0, 0, 0, 0, 0, STAT_OK);
        run_step_table();
        hold_until_drained();

        // catch any stray response after the last one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
            report_mismatch("responses never delivered", 64'(pending_replies.size()), 64'd0);

        $display("covered %0d requests (%0d random), %0d responses, deepest list %0d of %0d",
                 req_total, random_total, resp_total, deepest_list, DEPTH);
        $display("status ok/empty/full/range seen: %0d/%0d/%0d/%0d, mismatches %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
                 status_seen[STAT_RANGE], err_cnt);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ils_pkg.sv
rtl/indexed_list_store_top.sv
verif/tb_indexed_list_store_top.sv
